// File: hw/rtl/hires_wheel_scroll_filter_unit_assert.svh
// assertion macros shared by the filter modules
`ifndef HIRES_WHEEL_SCROLL_FILTER_UNIT_ASSERT_SVH
`define HIRES_WHEEL_SCROLL_FILTER_UNIT_ASSERT_SVH

// same-cycle implication, off during reset
`define HWSF_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, off during reset
`define HWSF_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hw/rtl/hwsf_pkg.sv
package hwsf_pkg;

  // input action codes
  localparam logic [2:0] ACT_LORES_V   = 3'd0;
  localparam logic [2:0] ACT_LORES_H   = 3'd1;
  localparam logic [2:0] ACT_HIRES_V   = 3'd2;
  localparam logic [2:0] ACT_HIRES_H   = 3'd3;
  localparam logic [2:0] ACT_FRAME_END = 3'd4;
  localparam logic [2:0] ACT_TICK      = 3'd5;

  // configuration register indexes
  localparam logic [1:0] REG_INITIAL_STRATEGY  = 2'd0;
  localparam logic [1:0] REG_TRIGGER_THRESHOLD = 2'd1;
  localparam logic [1:0] REG_INITIAL_MIN_STEP  = 2'd2;
  localparam logic [1:0] REG_SCROLL_TIMEOUT    = 2'd3;

  // register value that selects passthrough
  localparam logic [1:0] REG_STRATEGY_PASS = 2'd1;

  // reset values of the configuration registers
  localparam logic [1:0]  RST_INITIAL_STRATEGY  = 2'd0;
  localparam logic [6:0]  RST_TRIGGER_THRESHOLD = 7'd30;
  localparam logic [6:0]  RST_INITIAL_MIN_STEP  = 7'd47;
  localparam logic [23:0] RST_SCROLL_TIMEOUT    = 24'd500000;

  // decoded command word between front and back
  typedef struct packed {
    logic               lores;
    logic               hires;
    logic               vertical;
    logic               frame_end;
    logic               tick;
    logic signed [15:0] delta;
    logic [47:0]        time_us;
  } cmd_t;

  // result word
  typedef struct packed {
    logic [1:0]         axis_kind;
    logic signed [31:0] amount;
    logic               last;
  } res_t;

  // static configuration seen by the back end
  typedef struct packed {
    logic [1:0]  initial_strategy;
    logic [6:0]  trigger_threshold;
    logic [23:0] scroll_timeout_us;
  } cfg_t;

  // register writes that also reload live state
  typedef struct packed {
    logic       strategy_load;
    logic       min_step_load;
    logic [1:0] strategy_value;
    logic [6:0] min_step_value;
  } cfg_load_t;

endpackage

// File: hw/rtl/hwsf_front.sv
module hwsf_front #(
  parameter int DEPTH = 4
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  output logic               full,
  input  logic [2:0]         action,
  input  logic signed [15:0] delta,
  input  logic [47:0]        time_us,
  output logic               cmd_valid,
  output hwsf_pkg::cmd_t     cmd,
  input  logic               cmd_pop
);

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  hwsf_pkg::cmd_t cmd_in;
  logic           keep;
  logic           wr;
  hwsf_pkg::cmd_t mem [DEPTH];
  logic [PW-1:0]  wr_ptr;
  logic [PW-1:0]  rd_ptr;
  logic [CW-1:0]  count;

  // classify the action; unused codes are taken and dropped
  always_comb begin
    cmd_in         = '0;
    cmd_in.delta   = delta;
    cmd_in.time_us = time_us;
    keep           = 1'b1;
    unique case (action)
      hwsf_pkg::ACT_LORES_V: begin
        cmd_in.lores    = 1'b1;
        cmd_in.vertical = 1'b1;
      end
      hwsf_pkg::ACT_LORES_H: begin
        cmd_in.lores = 1'b1;
      end
      hwsf_pkg::ACT_HIRES_V: begin
        cmd_in.hires    = 1'b1;
        cmd_in.vertical = 1'b1;
      end
      hwsf_pkg::ACT_HIRES_H: begin
        cmd_in.hires = 1'b1;
      end
      hwsf_pkg::ACT_FRAME_END: begin
        cmd_in.frame_end = 1'b1;
      end
      hwsf_pkg::ACT_TICK: begin
        cmd_in.tick = 1'b1;
      end
      default: begin
        keep = 1'b0;
      end
    endcase
  end

  assign full      = (count == CW'(DEPTH));
  assign cmd_valid = (count != '0);
  assign cmd       = mem[rd_ptr];
  assign wr        = push && !full && keep;

  // command queue storage
  always_ff @(posedge clk) begin
    if (wr) begin
      mem[wr_ptr] <= cmd_in;
    end
  end

  // command queue pointers
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (cmd_pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({wr, cmd_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

// File: hw/rtl/hwsf_outq.sv
`include "hires_wheel_scroll_filter_unit_assert.svh"

module hwsf_outq #(
  parameter int DEPTH = 4
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  hwsf_pkg::res_t din,
  output logic           full,
  input  logic           pop,
  output logic           empty,
  output hwsf_pkg::res_t dout
);

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  hwsf_pkg::res_t mem [DEPTH];
  logic [PW-1:0]  wr_ptr;
  logic [PW-1:0]  rd_ptr;
  logic [CW-1:0]  count;
  logic           wr;
  logic           rd;

  assign full  = (count == CW'(DEPTH));
  assign empty = (count == '0);
  assign dout  = mem[rd_ptr];
  assign wr    = push && !full;
  assign rd    = pop && !empty;

  // result storage
  always_ff @(posedge clk) begin
    if (wr) begin
      mem[wr_ptr] <= din;
    end
  end

  // result queue pointers
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (rd) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({wr, rd})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  // back end must never push into a full queue
  `HWSF_ASSERT_IMPL(a_outq_no_overflow, clk, rst, push, !full, "result pushed while full")
  `HWSF_ASSERT_IMPL(a_outq_count_bound, clk, rst, 1'b1, count <= CW'(DEPTH), "count past depth")
  `HWSF_ASSERT_NEXT(a_outq_count_up, clk, rst, wr && !rd, count == CW'($past(count) + 1'b1), "count did not grow")

endmodule

// File: hw/rtl/hwsf_back.sv
`include "hires_wheel_scroll_filter_unit_assert.svh"

module hwsf_back (
  input  logic                clk,
  input  logic                rst,
  input  hwsf_pkg::cfg_t      cfg,
  input  hwsf_pkg::cfg_load_t cfg_load,
  input  logic                cmd_valid,
  input  hwsf_pkg::cmd_t      cmd,
  output logic                cmd_pop,
  input  logic                res_full,
  output logic                res_push,
  output hwsf_pkg::res_t      res
);

  // sequencer states
  localparam logic [1:0] B_RUN    = 2'd0;
  localparam logic [1:0] B_SCALE  = 2'd1;
  localparam logic [1:0] B_DECIDE = 2'd2;
  localparam logic [1:0] B_EMIT   = 2'd3;

  // scroll phases
  localparam logic [1:0] PH_IDLE   = 2'd0;
  localparam logic [1:0] PH_ACC    = 2'd1;
  localparam logic [1:0] PH_SCROLL = 2'd2;

  // live strategy codes
  localparam logic [1:0] ST_MAYBE  = 2'd0;
  localparam logic [1:0] ST_PASS   = 2'd1;
  localparam logic [1:0] ST_ACC    = 2'd2;
  localparam logic [1:0] ST_ALWAYS = 2'd3;

  // direction codes
  localparam logic [2:0] DIR_NONE = 3'd0;
  localparam logic [2:0] DIR_VPOS = 3'd1;
  localparam logic [2:0] DIR_VNEG = 3'd2;
  localparam logic [2:0] DIR_HPOS = 3'd3;
  localparam logic [2:0] DIR_HNEG = 3'd4;

  // result kinds
  localparam logic [1:0] KIND_HIRES_V = 2'd0;
  localparam logic [1:0] KIND_LORES_V = 2'd1;
  localparam logic [1:0] KIND_HIRES_H = 2'd2;
  localparam logic [1:0] KIND_LORES_H = 2'd3;

  localparam logic signed [31:0] SAT_MAX = 32'sh7fff_ffff;
  localparam logic signed [31:0] SAT_MIN = 32'sh8000_0000;

  function automatic logic [1:0] strategy_from_reg(input logic [1:0] r);
    logic [1:0] s;
    if (r == 2'd0) begin
      s = ST_MAYBE;
    end else if (r == 2'd1) begin
      s = ST_PASS;
    end else begin
      s = ST_ALWAYS;
    end
    return s;
  endfunction

  // saturating add of a wheel delta
  function automatic logic signed [31:0] sat_add(input logic signed [31:0] acc,
                                                  input logic signed [15:0] d);
    logic signed [32:0] s;
    logic signed [31:0] r;
    s = {acc[31], acc} + {{17{d[15]}}, d};
    if (s[32] != s[31]) begin
      r = s[32] ? SAT_MIN : SAT_MAX;
    end else begin
      r = s[31:0];
    end
    return r;
  endfunction

  // x * 120 as x * 128 - x * 8, saturated
  function automatic logic signed [31:0] scale_lores(input logic signed [31:0] x);
    logic signed [39:0] w;
    logic signed [31:0] r;
    w = {x[31], x, 7'b0} - {{5{x[31]}}, x, 3'b0};
    if (w[39:31] != {9{w[39]}}) begin
      r = w[39] ? SAT_MIN : SAT_MAX;
    end else begin
      r = w[31:0];
    end
    return r;
  endfunction

  // magnitude of x above the tracked step
  function automatic logic mag_gt(input logic signed [31:0] x, input logic [6:0] m);
    logic [32:0] a;
    a = x[31] ? (33'd0 - {x[31], x}) : {1'b0, x};
    return a > {26'b0, m};
  endfunction

  logic [1:0]         st, st_next;
  logic [1:0]         phase, phase_next;
  logic [1:0]         strategy, strategy_next;
  logic [2:0]         direction, direction_next;
  logic [6:0]         min_step, min_step_next;
  logic signed [31:0] hv, hv_next;
  logic signed [31:0] hh, hh_next;
  logic signed [31:0] lv, lv_next;
  logic signed [31:0] lh, lh_next;
  logic               hires_seen, hires_seen_next;
  logic               timer_armed, timer_armed_next;
  logic [47:0]        deadline, deadline_next;
  logic [47:0]        frame_time, frame_time_next;

  logic [16:0]        hires_mag;
  logic [6:0]         min_cand;
  logic [2:0]         dir_new;
  logic               delta_pos;
  logic               timer_usable;
  logic [3:0]         nz;
  logic               emit_last;

  assign timer_usable = (cfg.initial_strategy != hwsf_pkg::REG_STRATEGY_PASS);
  assign nz           = {lh != 32'sd0, hh != 32'sd0, lv != 32'sd0, hv != 32'sd0};
  assign emit_last    = ((nz & (nz - 4'd1)) == 4'd0);
  assign cmd_pop      = (st == B_RUN) && cmd_valid;
  assign res_push     = (st == B_EMIT) && !res_full;

  // hi-res step helpers
  assign hires_mag = cmd.delta[15] ? (17'd0 - {cmd.delta[15], cmd.delta})
                                   : {1'b0, cmd.delta};
  assign min_cand  = (hires_mag < {10'b0, min_step}) ? hires_mag[6:0] : min_step;
  assign delta_pos = !cmd.delta[15] && (cmd.delta != 16'sd0);
  assign dir_new   = cmd.vertical ? (delta_pos ? DIR_VPOS : DIR_VNEG)
                                  : (delta_pos ? DIR_HPOS : DIR_HNEG);

  // lowest nonzero accumulator goes out first
  always_comb begin
    res.last = emit_last;
    if (nz[0]) begin
      res.axis_kind = KIND_HIRES_V;
      res.amount    = hv;
    end else if (nz[1]) begin
      res.axis_kind = KIND_LORES_V;
      res.amount    = lv;
    end else if (nz[2]) begin
      res.axis_kind = KIND_HIRES_H;
      res.amount    = hh;
    end else begin
      res.axis_kind = KIND_LORES_H;
      res.amount    = lh;
    end
  end

  // sequencer and filter state update
  always_comb begin
    st_next          = st;
    phase_next       = phase;
    strategy_next    = strategy;
    direction_next   = direction;
    min_step_next    = min_step;
    hv_next          = hv;
    hh_next          = hh;
    lv_next          = lv;
    lh_next          = lh;
    hires_seen_next  = hires_seen;
    timer_armed_next = timer_armed;
    deadline_next    = deadline;
    frame_time_next  = frame_time;

    unique case (st)
      B_RUN: begin
        if (cmd_valid) begin
          if (cmd.lores || cmd.hires) begin
            // accumulate
            if (cmd.lores && cmd.vertical)   lv_next = sat_add(lv, cmd.delta);
            if (cmd.lores && !cmd.vertical)  lh_next = sat_add(lh, cmd.delta);
            if (cmd.hires && cmd.vertical)   hv_next = sat_add(hv, cmd.delta);
            if (cmd.hires && !cmd.vertical)  hh_next = sat_add(hh, cmd.delta);
            // step size tracking and direction change
            if (cmd.hires) begin
              hires_seen_next = 1'b1;
              if (strategy != ST_ALWAYS) begin
                min_step_next = min_cand;
                if (strategy == ST_MAYBE && min_cand < cfg.trigger_threshold) begin
                  strategy_next = ST_ACC;
                end
              end
              if (dir_new != direction) begin
                direction_next = dir_new;
                if (phase == PH_SCROLL) begin
                  timer_armed_next = 1'b0;
                end
                phase_next = PH_IDLE;
              end
            end
            // scroll event
            case (phase_next)
              PH_IDLE: begin
                phase_next = (strategy_next == ST_ACC || strategy_next == ST_ALWAYS)
                             ? PH_ACC : PH_SCROLL;
              end
              PH_ACC: begin
                phase_next = PH_ACC;
              end
              PH_SCROLL: begin
                if (timer_usable) begin
                  timer_armed_next = 1'b1;
                  deadline_next    = cmd.time_us + {24'b0, cfg.scroll_timeout_us};
                end
              end
              default: begin
                phase_next = PH_IDLE;
              end
            endcase
          end else if (cmd.tick) begin
            // timeout
            if (timer_armed && cmd.time_us >= deadline) begin
              timer_armed_next = 1'b0;
              if (phase != PH_ACC) begin
                phase_next = PH_IDLE;
              end
            end
          end else begin
            frame_time_next = cmd.time_us;
            st_next         = B_SCALE;
          end
        end
      end
      B_SCALE: begin
        // no hi-res seen yet: derive hi-res from lo-res
        if (!hires_seen && (lv != 32'sd0 || lh != 32'sd0)) begin
          hv_next = scale_lores(lv);
          hh_next = scale_lores(lh);
        end
        st_next = B_DECIDE;
      end
      B_DECIDE: begin
        st_next = B_RUN;
        case (phase)
          PH_ACC: begin
            if (mag_gt(hh, min_step) || mag_gt(hv, min_step)) begin
              phase_next = PH_SCROLL;
              if (timer_usable) begin
                timer_armed_next = 1'b1;
                deadline_next    = frame_time + {24'b0, cfg.scroll_timeout_us};
              end
              if (nz != 4'd0) st_next = B_EMIT;
            end
          end
          PH_SCROLL: begin
            if (nz != 4'd0) st_next = B_EMIT;
          end
          default: begin
            st_next = B_RUN;
          end
        endcase
      end
      B_EMIT: begin
        if (res_push) begin
          case (res.axis_kind)
            KIND_HIRES_V: hv_next = 32'sd0;
            KIND_LORES_V: lv_next = 32'sd0;
            KIND_HIRES_H: hh_next = 32'sd0;
            default:      lh_next = 32'sd0;
          endcase
          if (emit_last) st_next = B_RUN;
        end
      end
      default: begin
        st_next = B_RUN;
      end
    endcase

    // register writes that reload live state
    if (cfg_load.strategy_load) begin
      strategy_next = strategy_from_reg(cfg_load.strategy_value);
    end
    if (cfg_load.min_step_load) begin
      min_step_next = cfg_load.min_step_value;
    end
  end

  // state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      st          <= B_RUN;
      phase       <= PH_IDLE;
      strategy    <= strategy_from_reg(hwsf_pkg::RST_INITIAL_STRATEGY);
      direction   <= DIR_NONE;
      min_step    <= hwsf_pkg::RST_INITIAL_MIN_STEP;
      hv          <= 32'sd0;
      hh          <= 32'sd0;
      lv          <= 32'sd0;
      lh          <= 32'sd0;
      hires_seen  <= 1'b0;
      timer_armed <= 1'b0;
      deadline    <= '0;
    end else begin
      st          <= st_next;
      phase       <= phase_next;
      strategy    <= strategy_next;
      direction   <= direction_next;
      min_step    <= min_step_next;
      hv          <= hv_next;
      hh          <= hh_next;
      lv          <= lv_next;
      lh          <= lh_next;
      hires_seen  <= hires_seen_next;
      timer_armed <= timer_armed_next;
      deadline    <= deadline_next;
    end
  end

  // frame time payload
  always_ff @(posedge clk) begin
    frame_time <= frame_time_next;
  end

  `HWSF_ASSERT_NEXT(a_last_ends_frame, clk, rst, res_push && res.last, st == B_RUN, "frame did not end on last word")
  `HWSF_ASSERT_NEXT(a_emit_holds, clk, rst, (st == B_EMIT) && !(res_push && res.last), st == B_EMIT, "emit left early")
  `HWSF_ASSERT_IMPL(a_no_zero_word, clk, rst, res_push, res.amount != 32'sd0, "zero amount emitted")
  `HWSF_ASSERT_NEXT(a_hv_cleared, clk, rst, res_push && (res.axis_kind == KIND_HIRES_V), hv == 32'sd0, "accumulator not cleared")

endmodule

// File: hw/rtl/hires_wheel_scroll_filter_unit.sv
// Scroll-wheel report filter. Words are pushed while full is low and results
// are popped while empty is low; both sides are queues (CMD_DEPTH and
// OUT_DEPTH entries, at least 2 each). Wheel and tick words are handled in
// the back end sequencer's run state, so they stream at one per cycle while
// no frame end is in progress; a frame end leaves the run state for lo-res
// scaling, then the phase decision, then the emit state for any results
// (held there while the result queue is full), all on the back end's one
// state update path. Configuration writes are meant for an idle block:
// writing initial_strategy also reloads the live strategy, and writing
// initial_min_step also reloads the tracked smallest hi-res step.
module hires_wheel_scroll_filter_unit #(
  parameter int CMD_DEPTH = 4,
  parameter int OUT_DEPTH = 4
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  output logic               full,
  input  logic [2:0]         action,
  input  logic signed [15:0] delta,
  input  logic [47:0]        time_us,
  output logic               empty,
  input  logic               pop,
  output logic [1:0]         axis_kind,
  output logic signed [31:0] amount,
  output logic               last,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [23:0]        cfg_data
);

  hwsf_pkg::cfg_t      cfg;
  hwsf_pkg::cfg_load_t cfg_load;
  hwsf_pkg::cmd_t      cmd;
  hwsf_pkg::res_t      res;
  hwsf_pkg::res_t      res_head;
  logic                cmd_valid;
  logic                cmd_pop;
  logic                res_push;
  logic                res_full;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.initial_strategy  <= hwsf_pkg::RST_INITIAL_STRATEGY;
      cfg.trigger_threshold <= hwsf_pkg::RST_TRIGGER_THRESHOLD;
      cfg.scroll_timeout_us <= hwsf_pkg::RST_SCROLL_TIMEOUT;
    end else if (cfg_we) begin
      unique case (cfg_index)
        hwsf_pkg::REG_INITIAL_STRATEGY:  cfg.initial_strategy  <= cfg_data[1:0];
        hwsf_pkg::REG_TRIGGER_THRESHOLD: cfg.trigger_threshold <= cfg_data[6:0];
        hwsf_pkg::REG_SCROLL_TIMEOUT:    cfg.scroll_timeout_us <= cfg_data;
        default:                         cfg.initial_strategy  <= cfg.initial_strategy;
      endcase
    end
  end

  // writes that reload live state in the back end
  assign cfg_load.strategy_load  = cfg_we && (cfg_index == hwsf_pkg::REG_INITIAL_STRATEGY);
  assign cfg_load.min_step_load  = cfg_we && (cfg_index == hwsf_pkg::REG_INITIAL_MIN_STEP);
  assign cfg_load.strategy_value = cfg_data[1:0];
  assign cfg_load.min_step_value = cfg_data[6:0];

  // front: accept and classify
  hwsf_front #(
    .DEPTH(CMD_DEPTH)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .full     (full),
    .action   (action),
    .delta    (delta),
    .time_us  (time_us),
    .cmd_valid(cmd_valid),
    .cmd      (cmd),
    .cmd_pop  (cmd_pop)
  );

  // back: filter state and frame emission
  hwsf_back u_back (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .cfg_load (cfg_load),
    .cmd_valid(cmd_valid),
    .cmd      (cmd),
    .cmd_pop  (cmd_pop),
    .res_full (res_full),
    .res_push (res_push),
    .res      (res)
  );

  // result queue
  hwsf_outq #(
    .DEPTH(OUT_DEPTH)
  ) u_outq (
    .clk  (clk),
    .rst  (rst),
    .push (res_push),
    .din  (res),
    .full (res_full),
    .pop  (pop),
    .empty(empty),
    .dout (res_head)
  );

  assign axis_kind = res_head.axis_kind;
  assign amount    = res_head.amount;
  assign last      = res_head.last;

endmodule

// File: sim/tb_top.sv
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  // action codes the block ignores
  localparam logic [2:0] ACT_SPARE_LO = 3'd6;
  localparam logic [2:0] ACT_SPARE_HI = 3'd7;

  // initial_strategy register values besides passthrough
  localparam logic [1:0] STRAT_REG_MAYBE  = 2'd0;
  localparam logic [1:0] STRAT_REG_ALWAYS = 2'd2;
  localparam logic [1:0] STRAT_REG_THREE  = 2'd3;

  localparam longint LORES_SCALE = 120;
  localparam longint SUM_MAX = 2147483647;
  localparam longint SUM_MIN = -SUM_MAX - 1;
  localparam int SETTLE_CYCLES = 32;
  localparam int WATCHDOG_LIMIT = 2000;

  typedef enum logic [1:0] {PH_IDLE, PH_ACCUM, PH_SCROLLING} wheel_phase_e;
  typedef enum logic [1:0] {STRAT_MAYBE, STRAT_PASS, STRAT_ACCUM, STRAT_ALWAYS} strategy_e;
  typedef enum logic [2:0] {DIR_NONE, DIR_UP, DIR_DOWN, DIR_RIGHT, DIR_LEFT} direction_e;
  typedef enum logic [1:0] {EV_SCROLL, EV_ACCUMULATED, EV_TIMEOUT, EV_DIRCHG} wheel_event_e;
  typedef enum logic [1:0] {AXIS_HIRES_V, AXIS_LORES_V, AXIS_HIRES_H, AXIS_LORES_H} axis_e;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               push = 1'b0;
  logic               full;
  logic [2:0]         action = hwsf_pkg::ACT_TICK;
  logic signed [15:0] delta = '0;
  logic [47:0]        time_us = '0;
  logic               empty;
  logic               pop = 1'b0;
  logic [1:0]         axis_kind;
  logic signed [31:0] amount;
  logic               last;
  logic               cfg_we = 1'b0;
  logic [1:0]         cfg_index = hwsf_pkg::REG_INITIAL_STRATEGY;
  logic [23:0]        cfg_data = '0;

  hires_wheel_scroll_filter_unit dut (
    .clk(clk),
    .rst(rst),
    .push(push),
    .full(full),
    .action(action),
    .delta(delta),
    .time_us(time_us),
    .empty(empty),
    .pop(pop),
    .axis_kind(axis_kind),
    .amount(amount),
    .last(last),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  // clock
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // mirror of the configuration registers
  logic [1:0]  reg_strategy;
  logic [6:0]  reg_threshold;
  logic [23:0] reg_timeout;

  // filter state as predicted
  wheel_phase_e       wheel_phase;
  strategy_e          wheel_strategy;
  direction_e         wheel_dir;
  logic [15:0]        step_floor;
  logic signed [31:0] acc_hv, acc_hh, acc_lv, acc_lh;
  bit                 hires_reported;
  bit                 timer_on;
  logic [47:0]        timer_deadline;

  // scroll results still owed by the block, oldest first
  hwsf_pkg::res_t pending_scrolls[$];

  int errors = 0;
  bit idle_on = 1'b1;
  int unsigned stall_left = 0;
  int quiet_cycles = 0;

  // stimulus timeline and current gesture
  logic [47:0] clock_us = '0;
  logic [47:0] last_wheel_us = '0;
  bit g_hires = 1'b1;
  bit g_vertical = 1'b1;
  bit g_negative = 1'b0;

  function automatic strategy_e strategy_of(logic [1:0] r);
    if (r == STRAT_REG_MAYBE) return STRAT_MAYBE;
    if (r == hwsf_pkg::REG_STRATEGY_PASS) return STRAT_PASS;
    return STRAT_ALWAYS;
  endfunction

  function automatic logic signed [31:0] clamp32(longint v);
    if (v > SUM_MAX) return SUM_MAX[31:0];
    if (v < SUM_MIN) return SUM_MIN[31:0];
    return v[31:0];
  endfunction

  function automatic longint abs32(logic signed [31:0] v);
    longint w;
    w = v;
    return (w < 0) ? -w : w;
  endfunction

  function automatic void reset_filter();
    reg_strategy = hwsf_pkg::RST_INITIAL_STRATEGY;
    reg_threshold = hwsf_pkg::RST_TRIGGER_THRESHOLD;
    reg_timeout = hwsf_pkg::RST_SCROLL_TIMEOUT;
    wheel_phase = PH_IDLE;
    wheel_strategy = strategy_of(hwsf_pkg::RST_INITIAL_STRATEGY);
    wheel_dir = DIR_NONE;
    step_floor = {9'd0, hwsf_pkg::RST_INITIAL_MIN_STEP};
    acc_hv = '0;
    acc_hh = '0;
    acc_lv = '0;
    acc_lh = '0;
    hires_reported = 1'b0;
    timer_on = 1'b0;
    timer_deadline = '0;
  endfunction

  // register write, including the live state it reloads
  function automatic void mirror_config(logic [1:0] idx, logic [23:0] w);
    case (idx)
      hwsf_pkg::REG_INITIAL_STRATEGY: begin
        reg_strategy = w[1:0];
        wheel_strategy = strategy_of(w[1:0]);
      end
      hwsf_pkg::REG_TRIGGER_THRESHOLD: reg_threshold = w[6:0];
      hwsf_pkg::REG_INITIAL_MIN_STEP: begin
        step_floor = {9'd0, w[6:0]};
      end
      default: reg_timeout = w;
    endcase
  endfunction

  // no scroll timer at all in passthrough
  function automatic void start_timer(logic [47:0] t);
    if (reg_strategy != hwsf_pkg::REG_STRATEGY_PASS) begin
      timer_on = 1'b1;
      timer_deadline = t + {24'd0, reg_timeout};
    end
  endfunction

  function automatic void phase_event(wheel_event_e ev, logic [47:0] t);
    case (wheel_phase)
      PH_IDLE: begin
        if (ev == EV_SCROLL)
          wheel_phase = (wheel_strategy == STRAT_ACCUM || wheel_strategy == STRAT_ALWAYS) ?
                        PH_ACCUM : PH_SCROLLING;
      end
      PH_ACCUM: begin
        if (ev == EV_ACCUMULATED) begin
          wheel_phase = PH_SCROLLING;
          start_timer(t);
        end else if (ev == EV_DIRCHG) begin
          wheel_phase = PH_IDLE;
        end
      end
      PH_SCROLLING: begin
        if (ev == EV_SCROLL) begin
          start_timer(t);
        end else if (ev == EV_TIMEOUT) begin
          wheel_phase = PH_IDLE;
        end else if (ev == EV_DIRCHG) begin
          timer_on = 1'b0;
          wheel_phase = PH_IDLE;
        end
      end
      default: wheel_phase = PH_IDLE;
    endcase
  endfunction

  // smallest step tracking, direction, then the scroll itself
  function automatic void hires_report(logic signed [15:0] d, bit vertical, logic [47:0] t);
    longint m;
    direction_e nd;
    m = d;
    if (m < 0) m = -m;
    hires_reported = 1'b1;
    if (wheel_strategy != STRAT_ALWAYS) begin
      if (m < longint'(step_floor)) step_floor = m[15:0];
      if (wheel_strategy == STRAT_MAYBE && step_floor < {9'd0, reg_threshold})
        wheel_strategy = STRAT_ACCUM;
    end
    // a zero step counts as the negative direction
    if (vertical) nd = (d > 0) ? DIR_UP : DIR_DOWN;
    else nd = (d > 0) ? DIR_RIGHT : DIR_LEFT;
    if (nd != wheel_dir) begin
      wheel_dir = nd;
      phase_event(EV_DIRCHG, t);
    end
    phase_event(EV_SCROLL, t);
  endfunction

  function automatic void owe_result(axis_e kind, logic signed [31:0] v);
    hwsf_pkg::res_t r;
    r.axis_kind = kind;
    r.amount = v;
    r.last = 1'b0;
    if (v != 0) pending_scrolls.push_back(r);
  endfunction

  // every nonzero accumulator goes out in fixed order and is cleared
  function automatic void flush_accumulators();
    int before_n;
    before_n = pending_scrolls.size();
    owe_result(AXIS_HIRES_V, acc_hv);
    owe_result(AXIS_LORES_V, acc_lv);
    owe_result(AXIS_HIRES_H, acc_hh);
    owe_result(AXIS_LORES_H, acc_lh);
    acc_hv = '0;
    acc_lv = '0;
    acc_hh = '0;
    acc_lh = '0;
    if (pending_scrolls.size() > before_n)
      pending_scrolls[pending_scrolls.size() - 1].last = 1'b1;
  endfunction

  function automatic void frame_end(logic [47:0] t);
    // only lo-res reports so far: hi-res takes the scaled lo-res value
    if (!hires_reported && (acc_lh != 0 || acc_lv != 0)) begin
      acc_hh = clamp32(longint'(acc_lh) * LORES_SCALE);
      acc_hv = clamp32(longint'(acc_lv) * LORES_SCALE);
    end
    if (wheel_phase == PH_ACCUM) begin
      if (abs32(acc_hh) > longint'(step_floor) || abs32(acc_hv) > longint'(step_floor)) begin
        phase_event(EV_ACCUMULATED, t);
        flush_accumulators();
      end
    end else if (wheel_phase == PH_SCROLLING) begin
      flush_accumulators();
    end
  endfunction

  // next filter state and owed results for one accepted word
  function automatic void advance_filter(logic [2:0] a, logic signed [15:0] d, logic [47:0] t);
    case (a)
      hwsf_pkg::ACT_LORES_V: begin
        acc_lv = clamp32(longint'(acc_lv) + longint'(d));
        phase_event(EV_SCROLL, t);
      end
      hwsf_pkg::ACT_LORES_H: begin
        acc_lh = clamp32(longint'(acc_lh) + longint'(d));
        phase_event(EV_SCROLL, t);
      end
      hwsf_pkg::ACT_HIRES_V: begin
        acc_hv = clamp32(longint'(acc_hv) + longint'(d));
        hires_report(d, 1'b1, t);
      end
      hwsf_pkg::ACT_HIRES_H: begin
        acc_hh = clamp32(longint'(acc_hh) + longint'(d));
        hires_report(d, 1'b0, t);
      end
      hwsf_pkg::ACT_FRAME_END: frame_end(t);
      hwsf_pkg::ACT_TICK: begin
        if (timer_on && t >= timer_deadline) begin
          timer_on = 1'b0;
          phase_event(EV_TIMEOUT, t);
        end
      end
      default: ;
    endcase
  endfunction

  function automatic logic [47:0] later(int unsigned gap_us);
    clock_us = clock_us + 48'(gap_us);
    return clock_us;
  endfunction

  // push one word, sometimes with a random gap ahead of it
  task automatic send_word(logic [2:0] a, logic signed [15:0] d, logic [47:0] t);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      push <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk);
    end
    push <= 1'b1;
    action <= a;
    delta <= d;
    time_us <= t;
    do @(posedge clk); while (full);
    advance_filter(a, d, t);
  endtask

  // drain owed results, then let words without results finish
  task automatic settle();
    push <= 1'b0;
    while (pending_scrolls.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic put_reg(logic [1:0] idx, logic [23:0] w);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= w;
    @(posedge clk);
    mirror_config(idx, w);
  endtask

  // all four registers, with junk above each narrow field
  task automatic write_config(logic [1:0] strat, logic [6:0] thr, logic [6:0] mins,
                              logic [23:0] tmo);
    logic [23:0] w;
    settle();
    w = 24'($urandom);
    w[1:0] = strat;
    put_reg(hwsf_pkg::REG_INITIAL_STRATEGY, w);
    w = 24'($urandom);
    w[6:0] = thr;
    put_reg(hwsf_pkg::REG_TRIGGER_THRESHOLD, w);
    w = 24'($urandom);
    w[6:0] = mins;
    put_reg(hwsf_pkg::REG_INITIAL_MIN_STEP, w);
    put_reg(hwsf_pkg::REG_SCROLL_TIMEOUT, tmo);
    cfg_we <= 1'b0;
  endtask

  // mostly gestures with random content, some noise words
  task automatic random_words(int words);
    int sent;
    int pick;
    int unsigned step;
    logic [2:0] a;
    logic signed [15:0] d;
    logic [47:0] t;
    sent = 0;
    while (sent < words) begin
      pick = $urandom_range(0, 99);
      d = 16'($urandom);
      if (pick < 8) begin
        a = 3'($urandom_range(0, 7));
        t = {16'($urandom), 32'($urandom)};
      end else if (pick < 24) begin
        a = hwsf_pkg::ACT_FRAME_END;
        t = later($urandom_range(0, 5000));
      end else if (pick < 34) begin
        a = hwsf_pkg::ACT_TICK;
        // land right around the deadline of the last wheel word, or just move on
        if ($urandom_range(0, 1) == 1) begin
          t = last_wheel_us + {24'd0, reg_timeout} + 48'($urandom_range(0, 2)) - 48'd1;
          clock_us = t;
        end else begin
          t = later($urandom_range(0, 200000));
        end
      end else begin
        if ($urandom_range(0, 6) == 0) begin
          g_hires = ($urandom_range(0, 3) != 0);
          g_vertical = 1'($urandom_range(0, 1));
          g_negative = 1'($urandom_range(0, 1));
        end
        if (!g_hires) begin
          step = $urandom_range(1, 3);
          a = g_vertical ? hwsf_pkg::ACT_LORES_V : hwsf_pkg::ACT_LORES_H;
        end else begin
          case ($urandom_range(0, 9))
            0: step = 0;
            1: step = $urandom_range(121, 32767);
            default: step = $urandom_range(1, 120);
          endcase
          a = g_vertical ? hwsf_pkg::ACT_HIRES_V : hwsf_pkg::ACT_HIRES_H;
        end
        d = 16'(step);
        if (g_negative) d = -d;
        t = later($urandom_range(0, 5000));
        last_wheel_us = t;
      end
      send_word(a, d, t);
      if (a <= hwsf_pkg::ACT_TICK) sent++;
    end
  endtask

  // lo-res only: scaling by 120 of small and of large sums
  task automatic test_lores_scaling();
    send_word(hwsf_pkg::ACT_FRAME_END, 16'sd0, later(1));
    send_word(hwsf_pkg::ACT_LORES_V, 16'sd1, later(5));
    send_word(hwsf_pkg::ACT_LORES_H, -16'sd1, later(5));
    send_word(hwsf_pkg::ACT_FRAME_END, 16'sd0, later(5));
    idle_on = 1'b0;
    repeat (4) send_word(hwsf_pkg::ACT_LORES_V, 16'sh7fff, later(1));
    repeat (4) send_word(hwsf_pkg::ACT_LORES_H, 16'h8000, later(1));
    idle_on = 1'b1;
    send_word(hwsf_pkg::ACT_FRAME_END, 16'sd0, later(1));
  endtask

  // hi-res accumulator carried well past the 16-bit range
  task automatic test_hires_large_sums();
    idle_on = 1'b0;
    repeat (10) send_word(hwsf_pkg::ACT_HIRES_V, 16'sh7fff, later(1));
    idle_on = 1'b1;
    send_word(hwsf_pkg::ACT_FRAME_END, 16'sd0, later(1));
  endtask

  // strategies, phases, direction changes, timeouts and ignored actions
  task automatic test_directed();
    write_config(STRAT_REG_ALWAYS, 7'd30, 7'd47, 24'd1000);
    send_word(hwsf_pkg::ACT_TICK, 16'sd0, later(3000000));
    send_word(hwsf_pkg::ACT_FRAME_END, 16'sd0, later(10));
    send_word(hwsf_pkg::ACT_HIRES_V, 16'sd5, later(10));
    send_word(hwsf_pkg::ACT_FRAME_END, 16'sd0, later(10));
    send_word(hwsf_pkg::ACT_HIRES_V, 16'sd60, later(10));
    send_word(hwsf_pkg::ACT_FRAME_END, 16'sd0, later(10));
    send_word(hwsf_pkg::ACT_HIRES_V, 16'sd0, later(10));
    send_word(hwsf_pkg::ACT_HIRES_H, 16'sh7fff, later(10));
    send_word(hwsf_pkg::ACT_HIRES_H, 16'h8000, later(10));
    send_word(hwsf_pkg::ACT_LORES_V, 16'h8000, later(10));
    send_word(hwsf_pkg::ACT_LORES_H, 16'sh7fff, later(10));
    send_word(hwsf_pkg::ACT_FRAME_END, 16'hffff, later(10));
    send_word(ACT_SPARE_LO, 16'hffff, 48'hffff_ffff_ffff);
    send_word(ACT_SPARE_HI, 16'sd1, later(1));
    send_word(hwsf_pkg::ACT_TICK, 16'hffff, later(999));

    // deadline wraps past the top of the 48-bit timestamp
    write_config(STRAT_REG_MAYBE, 7'd120, 7'd120, 24'hffffff);
    clock_us = 48'hffff_ffff_ff00;
    send_word(hwsf_pkg::ACT_HIRES_V, 16'sd1, later(1));
    send_word(hwsf_pkg::ACT_HIRES_V, 16'sd100, later(1));
    send_word(hwsf_pkg::ACT_FRAME_END, 16'sd0, later(1));
    send_word(hwsf_pkg::ACT_TICK, 16'sd0, later(16));

    // passthrough never arms the timer
    write_config(hwsf_pkg::REG_STRATEGY_PASS, 7'd30, 7'd47, 24'd0);
    send_word(hwsf_pkg::ACT_HIRES_V, 16'sd10, later(1));
    send_word(hwsf_pkg::ACT_HIRES_V, 16'sd10, later(1));
    send_word(hwsf_pkg::ACT_FRAME_END, 16'sd0, later(1));
    send_word(hwsf_pkg::ACT_TICK, 16'sd0, later(100));

    // register value three behaves as always accumulate
    write_config(STRAT_REG_THREE, 7'd0, 7'd0, 24'd1);
    send_word(hwsf_pkg::ACT_HIRES_H, -16'sd1, later(1));
    send_word(hwsf_pkg::ACT_FRAME_END, 16'sd0, later(1));
    send_word(hwsf_pkg::ACT_TICK, 16'sd0, later(1));
  endtask

  task automatic test_random_settings();
    write_config(STRAT_REG_MAYBE, hwsf_pkg::RST_TRIGGER_THRESHOLD,
                 hwsf_pkg::RST_INITIAL_MIN_STEP, hwsf_pkg::RST_SCROLL_TIMEOUT);
    random_words(30);
    write_config(STRAT_REG_MAYBE, 7'd120, 7'd120, 24'd0);
    random_words(30);
    idle_on = 1'b0;
    write_config(STRAT_REG_ALWAYS, 7'd0, 7'd0, 24'hffffff);
    random_words(30);
    idle_on = 1'b1;
    write_config(hwsf_pkg::REG_STRATEGY_PASS, 7'd60, 7'd10, 24'd2000);
    random_words(30);
    write_config(STRAT_REG_THREE, 7'($urandom_range(0, 120)), 7'($urandom_range(0, 120)),
                 24'($urandom_range(0, 20000)));
    random_words(30);
  endtask

  // back-to-back traffic, no gaps or stalls on either side
  task automatic test_streaming();
    idle_on = 1'b0;
    write_config(STRAT_REG_MAYBE, 7'd30, 7'd47, 24'd3000);
    random_words(35);
  endtask

  // result check and receiver stalls
  always @(posedge clk) begin : result_check
    hwsf_pkg::res_t want;
    if (!rst && pop && !empty) begin
      if (pending_scrolls.size() == 0) begin
        errors++;
        $display("%0t: expected no word, actual axis_kind %0d amount %0d last %0d",
                 $time, axis_kind, amount, last);
      end else begin
        want = pending_scrolls.pop_front();
        if (axis_kind !== want.axis_kind) begin
          errors++;
          $display("%0t: axis_kind expected %0d actual %0d", $time, want.axis_kind, axis_kind);
        end
        if (amount !== want.amount) begin
          errors++;
          $display("%0t: amount expected %0d actual %0d", $time, want.amount, amount);
        end
        if (last !== want.last) begin
          errors++;
          $display("%0t: last expected %0d actual %0d", $time, want.last, last);
        end
      end
    end
    if (stall_left != 0) begin
      stall_left--;
      pop <= 1'b0;
    end else if (idle_on && $urandom_range(0, 4) == 0) begin
      stall_left = $urandom_range(1, 11) - 1;
      pop <= 1'b0;
    end else begin
      pop <= 1'b1;
    end
  end

  // watchdog on cycles with no word moving either way
  always @(posedge clk) begin
    if ((push && !full) || (pop && !empty)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("tb_top: errors");
      $finish;
    end
  end

  initial begin
    reset_filter();
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    test_lores_scaling();
    test_hires_large_sums();
    test_directed();
    test_random_settings();
    test_streaming();
    settle();
    if (errors == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

endmodule
